FILE: rtl/core/fnu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Face normal unit package
// Request types and the fixed widths of the face normal datapath.
// ----------------------------------------------------------------------------
package fnu_pkg;

    localparam int COORD_W   = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int NORM_MSB  = 30;
    localparam int U_W       = NORM_MSB + 1;
    localparam int SQ_W      = 2 * U_W;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int FRAC_W    = 14;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int REM_W     = ROOT_W + FRAC_W;
    localparam int TOP_W     = $clog2(CROSS_W);
    localparam int ONE_Q14   = 1 << FRAC_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_face_in;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               degenerate;
    } t_face_out;

endpackage
`default_nettype wire

FILE: rtl/core/face_unit_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Face unit normal
// Cross product of two triangle edges, scaled to unit length in Q1.14.
// ----------------------------------------------------------------------------
// One triangle is accepted every clock cycle unless the output is stalled. Six
// stages form the edges, the cross product, its magnitudes and a common
// scaling shift, one stage squares and one sums, 32 stages take the integer
// square root one result bit each, one stage forms the rounded dividends, 15
// stages divide the three components in parallel one quotient bit each, and
// one output register holds the result. The pipeline advances as a whole; a
// stalled output register holds every stage, so no request is lost or
// repeated.
module face_unit_normal (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire fnu_pkg::t_face_in i_face,
    output logic                o_valid,
    input  wire                 i_stall,
    output fnu_pkg::t_face_out  o_face
);
    import fnu_pkg::*;

    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = QUO_W;

    typedef struct packed {
        logic [2:0]          neg;
        logic                degen;
        logic [2:0][U_W-1:0] u;
    } t_car;

    logic en;

    // Stage 1: edges
    logic                     r1_v;
    logic signed [EDGE_W-1:0] r1_e1 [3];
    logic signed [EDGE_W-1:0] r1_e2 [3];
    // Stage 2: products
    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_p [6];
    // Stage 3: cross product
    logic                      r3_v;
    logic signed [CROSS_W-1:0] r3_n [3];
    // Stage 4: magnitudes
    logic                 r4_v;
    logic [CROSS_W-1:0]   r4_u [3];
    logic [2:0]           r4_neg;
    // Stage 5: top bit of the largest magnitude
    logic                 r5_v;
    logic [CROSS_W-1:0]   r5_u [3];
    logic [2:0]           r5_neg;
    logic [TOP_W-1:0]     r5_p;
    logic                 r5_degen;
    // Stage 6: normalised magnitudes
    logic                 r6_v;
    t_car                 r6_c;
    // Stage 7: squares
    logic                 r7_v;
    t_car                 r7_c;
    logic [SQ_W-1:0]      r7_sq [3];
    // Square root stages
    logic                 r_sq_v    [SQ_STEPS+1];
    logic [SUM_W-1:0]     r_sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]    r_sq_root [SQ_STEPS+1];
    t_car                 r_sq_c    [SQ_STEPS+1];
    logic [SUM_W-1:0]     n_sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]    n_sq_root [SQ_STEPS+1];
    // Division stages
    logic                 r_dv_v    [DIV_STEPS+1];
    logic [ROOT_W-1:0]    r_dv_len  [DIV_STEPS+1];
    logic [2:0]           r_dv_neg  [DIV_STEPS+1];
    logic                 r_dv_dg   [DIV_STEPS+1];
    logic [2:0][REM_W-1:0] r_dv_rem [DIV_STEPS+1];
    logic [2:0][QUO_W-1:0] r_dv_q   [DIV_STEPS+1];
    logic [2:0][REM_W-1:0] n_dv_rem [DIV_STEPS+1];
    logic [2:0][QUO_W-1:0] n_dv_q   [DIV_STEPS+1];
    // Output
    logic                 r_ov;
    t_face_out            r_out;
    t_face_out            n_out;

    logic [CROSS_W-1:0]   w_max;
    logic [TOP_W-1:0]     w_top;
    logic [CROSS_W+NORM_MSB-1:0] w_shift [3];

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;
    assign o_valid = r_ov;
    assign o_face  = r_out;

    always_comb begin
        w_max = r4_u[0];
        if (r4_u[1] > w_max) begin
            w_max = r4_u[1];
        end
        if (r4_u[2] > w_max) begin
            w_max = r4_u[2];
        end
        w_top = '0;
        for (int i = 0; i < CROSS_W; i++) begin
            if (w_max[i]) begin
                w_top = TOP_W'(i);
            end
        end
    end

    // Shifting left by the fixed amount and back by the top bit position
    // puts the top bit of the largest magnitude at bit 30, truncating.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_shift[i] = {r5_u[i], {NORM_MSB{1'b0}}} >> r5_p;
        end
    end

    always_comb begin
        for (int j = 0; j < SQ_STEPS; j++) begin
            logic [SUM_W+1:0] trial;
            trial = ((SUM_W+2)'(r_sq_root[j]) << (SQ_STEPS - j))
                  + ((SUM_W+2)'(1) << (2 * (SQ_STEPS - 1 - j)));
            if ({2'b00, r_sq_rem[j]} >= trial) begin
                n_sq_rem[j+1]  = r_sq_rem[j] - SUM_W'(trial);
                n_sq_root[j+1] = r_sq_root[j] | (ROOT_W'(1) << (SQ_STEPS - 1 - j));
            end else begin
                n_sq_rem[j+1]  = r_sq_rem[j];
                n_sq_root[j+1] = r_sq_root[j];
            end
        end
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
    end

    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int i = 0; i < 3; i++) begin
                logic [REM_W-1:0] dvs;
                dvs = REM_W'(r_dv_len[j]) << (DIV_STEPS - 1 - j);
                if (r_dv_rem[j][i] >= dvs) begin
                    n_dv_rem[j+1][i] = r_dv_rem[j][i] - dvs;
                    n_dv_q[j+1][i]   = r_dv_q[j][i] | (QUO_W'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    n_dv_rem[j+1][i] = r_dv_rem[j][i];
                    n_dv_q[j+1][i]   = r_dv_q[j][i];
                end
            end
        end
        n_dv_rem[0] = '0;
        n_dv_q[0]   = '0;
    end

    always_comb begin
        logic [QUO_W-1:0] q;
        logic signed [15:0] c [3];
        for (int i = 0; i < 3; i++) begin
            q = r_dv_q[DIV_STEPS][i];
            if (q > QUO_W'(ONE_Q14)) begin
                q = QUO_W'(ONE_Q14);
            end
            if (r_dv_dg[DIV_STEPS]) begin
                c[i] = '0;
            end else if (r_dv_neg[DIV_STEPS][i]) begin
                c[i] = -$signed({1'b0, q});
            end else begin
                c[i] = $signed({1'b0, q});
            end
        end
        n_out.norm_x     = c[0];
        n_out.norm_y     = c[1];
        n_out.norm_z     = c[2];
        n_out.degenerate = r_dv_dg[DIV_STEPS];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r_ov <= 1'b0;
            for (int j = 0; j <= SQ_STEPS; j++) begin
                r_sq_v[j] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r_sq_v[0] <= r7_v;
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            r_ov <= r_dv_v[DIV_STEPS];
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e1[0] <= EDGE_W'(i_face.bx) - EDGE_W'(i_face.ax);
            r1_e1[1] <= EDGE_W'(i_face.by) - EDGE_W'(i_face.ay);
            r1_e1[2] <= EDGE_W'(i_face.bz) - EDGE_W'(i_face.az);
            r1_e2[0] <= EDGE_W'(i_face.cx) - EDGE_W'(i_face.ax);
            r1_e2[1] <= EDGE_W'(i_face.cy) - EDGE_W'(i_face.ay);
            r1_e2[2] <= EDGE_W'(i_face.cz) - EDGE_W'(i_face.az);

            r2_p[0] <= r1_e1[1] * r1_e2[2];
            r2_p[1] <= r1_e1[2] * r1_e2[1];
            r2_p[2] <= r1_e1[2] * r1_e2[0];
            r2_p[3] <= r1_e1[0] * r1_e2[2];
            r2_p[4] <= r1_e1[0] * r1_e2[1];
            r2_p[5] <= r1_e1[1] * r1_e2[0];

            for (int i = 0; i < 3; i++) begin
                r3_n[i] <= CROSS_W'(r2_p[2*i]) - CROSS_W'(r2_p[2*i+1]);
            end

            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= r3_n[i][CROSS_W-1];
                r4_u[i]   <= r3_n[i][CROSS_W-1] ? CROSS_W'(-r3_n[i])
                                                : CROSS_W'(r3_n[i]);
            end

            r5_u     <= r4_u;
            r5_neg   <= r4_neg;
            r5_p     <= w_top;
            r5_degen <= (w_max == '0);

            r6_c.neg   <= r5_neg;
            r6_c.degen <= r5_degen;
            for (int i = 0; i < 3; i++) begin
                r6_c.u[i] <= w_shift[i][U_W-1:0];
            end

            r7_c <= r6_c;
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= SQ_W'(r6_c.u[i]) * SQ_W'(r6_c.u[i]);
            end

            r_sq_rem[0]  <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
            r_sq_root[0] <= '0;
            r_sq_c[0]    <= r7_c;
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_sq_rem[j+1]  <= n_sq_rem[j+1];
                r_sq_root[j+1] <= n_sq_root[j+1];
                r_sq_c[j+1]    <= r_sq_c[j];
            end

            // Numerator carries half the length so the quotient rounds half up.
            r_dv_len[0] <= r_sq_root[SQ_STEPS];
            r_dv_neg[0] <= r_sq_c[SQ_STEPS].neg;
            r_dv_dg[0]  <= r_sq_c[SQ_STEPS].degen;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (REM_W'(r_sq_c[SQ_STEPS].u[i]) << FRAC_W)
                                + REM_W'(r_sq_root[SQ_STEPS] >> 1);
            end
            r_dv_q[0] <= '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
                r_dv_dg[j+1]  <= r_dv_dg[j];
                r_dv_rem[j+1] <= n_dv_rem[j+1];
                r_dv_q[j+1]   <= n_dv_q[j+1];
            end

            r_out <= n_out;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("pipeline held without a waiting result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_face.degenerate) |->
        (o_face.norm_x == 16'sd0 && o_face.norm_y == 16'sd0 && o_face.norm_z == 16'sd0))
        else $error("degenerate face with non-zero normal");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face.norm_x <= 16'sd16384 && o_face.norm_x >= -16'sd16384
                  && o_face.norm_y <= 16'sd16384 && o_face.norm_y >= -16'sd16384
                  && o_face.norm_z <= 16'sd16384 && o_face.norm_z >= -16'sd16384))
        else $error("normal component beyond unit range");

endmodule
`default_nettype wire

FILE: tb/face_unit_normal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face unit normal testbench
// Drives triangles into the face normal pipeline with random idling on both
// sides. Each accepted request is predicted here and every normal is checked
// in order, field by field.
// ----------------------------------------------------------------------------
module face_unit_normal_tb;

    import fnu_pkg::*;

    class normal_scoreboard;
        t_face_out pending_normals[$];
        int        error_count;

        function new();
            error_count = 0;
        endfunction

        // Exact cross product, common shift to bit 30, integer root, rounded divide.
        function t_face_out predict(t_face_in f);
            t_face_out   res;
            logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z;
            logic signed [63:0] nv[3];
            logic [63:0] u[3];
            logic [63:0] m, s, len, rem, bit_v, q;
            int          p;
            e1x = 64'(f.bx) - 64'(f.ax);
            e1y = 64'(f.by) - 64'(f.ay);
            e1z = 64'(f.bz) - 64'(f.az);
            e2x = 64'(f.cx) - 64'(f.ax);
            e2y = 64'(f.cy) - 64'(f.ay);
            e2z = 64'(f.cz) - 64'(f.az);
            nv[0] = e1y * e2z - e1z * e2y;
            nv[1] = e1z * e2x - e1x * e2z;
            nv[2] = e1x * e2y - e1y * e2x;
            m = 0;
            for (int i = 0; i < 3; i++) begin
                u[i] = nv[i] < 0 ? -nv[i] : nv[i];
                if (u[i] > m) m = u[i];
            end
            res = '0;
            if (m == 0) begin
                res.degenerate = 1'b1;
                return res;
            end
            p = 0;
            for (int b = 0; b < 64; b++) if (m[b]) p = b;
            for (int i = 0; i < 3; i++)
                u[i] = (p > 30) ? (u[i] >> (p - 30)) : (u[i] << (30 - p));
            s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            len = 0;
            rem = s;
            bit_v = 64'd1 << 62;
            while (bit_v > rem) bit_v >>= 2;
            while (bit_v != 0) begin
                if (rem >= len + bit_v) begin
                    rem -= len + bit_v;
                    len = (len >> 1) + bit_v;
                end else begin
                    len >>= 1;
                end
                bit_v >>= 2;
            end
            for (int i = 0; i < 3; i++) begin
                q = ((u[i] << 14) + (len >> 1)) / len;
                if (q > ONE_Q14) q = ONE_Q14;
                if (nv[i] < 0) q = -q;
                if (i == 0) res.norm_x = q[15:0];
                else if (i == 1) res.norm_y = q[15:0];
                else res.norm_z = q[15:0];
            end
            return res;
        endfunction

        function void note_request(t_face_in f);
            pending_normals.insert(pending_normals.size(), predict(f));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        task check_result(t_face_out got);
            t_face_out want;
            if (pending_normals.size() == 0) begin
                report("normal with no request outstanding");
                return;
            end
            want = pending_normals.pop_front();
            if (got.norm_x !== want.norm_x)
                report($sformatf("norm_x %0d, expected %0d", got.norm_x, want.norm_x));
            if (got.norm_y !== want.norm_y)
                report($sformatf("norm_y %0d, expected %0d", got.norm_y, want.norm_y));
            if (got.norm_z !== want.norm_z)
                report($sformatf("norm_z %0d, expected %0d", got.norm_z, want.norm_z));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate %0b, expected %0b",
                                 got.degenerate, want.degenerate));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_face_in  i_face;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_face_out o_face;

    normal_scoreboard sb;
    bit        quiet_tail;
    int        idle_left = 0;

    face_unit_normal uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_face  (i_face),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_face  (o_face)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall bursts, checks on accepted normals.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_face);
        if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            i_stall   <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(0, 2);
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_face_in random_face();
        t_face_in f;
        logic [159:0] raw;
        logic signed [15:0] base[3];
        int mode;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        f = raw[143:0];
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            // collinear vertices: C repeats A or B
            if ($urandom_range(0, 1)) {f.cx, f.cy, f.cz} = {f.ax, f.ay, f.az};
            else {f.cx, f.cy, f.cz} = {f.bx, f.by, f.bz};
        end else if (mode < 4) begin
            // small triangle around a random point
            base = '{16'($urandom), 16'($urandom), 16'($urandom)};
            f.ax = base[0] + 16'($signed($urandom_range(0, 8)) - 4);
            f.ay = base[1] + 16'($signed($urandom_range(0, 8)) - 4);
            f.az = base[2] + 16'($signed($urandom_range(0, 8)) - 4);
            f.bx = base[0] + 16'($signed($urandom_range(0, 8)) - 4);
            f.by = base[1] + 16'($signed($urandom_range(0, 8)) - 4);
            f.bz = base[2] + 16'($signed($urandom_range(0, 8)) - 4);
            f.cx = base[0] + 16'($signed($urandom_range(0, 8)) - 4);
            f.cy = base[1] + 16'($signed($urandom_range(0, 8)) - 4);
            f.cz = base[2] + 16'($signed($urandom_range(0, 8)) - 4);
        end
        return f;
    endfunction

    // Holds the request until it is taken; valid stays high only with keep_busy.
    task automatic send_face(t_face_in f, bit keep_busy);
        int gap;
        gap = keep_busy ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_face  <= f;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(f);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending_normals.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        t_face_in f;
        logic signed [15:0] ext[4];
        sb         = new();
        quiet_tail = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_face     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate, axis-aligned, extremes and rounding cases.
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        send_face('0, 1'b0);
        send_face('{ax: 0, ay: 0, az: 0, bx: 256, by: 0, bz: 0,
                    cx: 0, cy: 256, cz: 0}, 1'b0);
        send_face('{ax: 0, ay: 0, az: 0, bx: 0, by: 256, bz: 0,
                    cx: 256, cy: 0, cz: 0}, 1'b0);
        send_face('{ax: 0, ay: 0, az: 0, bx: 0, by: 1, bz: 0,
                    cx: 0, cy: 0, cz: 1}, 1'b0);
        send_face('{ax: 1, ay: 1, az: 1, bx: 2, by: 2, bz: 2,
                    cx: 3, cy: 3, cz: 3}, 1'b0);
        send_face('{ax: 0, ay: 0, az: 0, bx: 1, by: 0, bz: 0,
                    cx: 1, cy: 1, cz: 1}, 1'b0);
        for (int k = 0; k < 16; k++) begin
            f.ax = ext[k % 4];       f.ay = ext[(k + 1) % 4]; f.az = ext[(k + 2) % 4];
            f.bx = ext[(k / 4) % 4]; f.by = ext[(k + 3) % 4]; f.bz = ext[k % 4];
            f.cx = ext[(k + 2) % 4]; f.cy = ext[(k / 4 + 1) % 4];
            f.cz = ext[(k / 4 + 3) % 4];
            send_face(f, 1'b0);
        end
        send_face({9{16'sh7fff}}, 1'b0);
        send_face({9{16'sh8000}}, 1'b0);

        for (int k = 0; k < 1950; k++) begin
            if (k == 1700) quiet_tail = 1'b1;
            if (k == 900) begin
                // sender holds off until the pipeline is empty
                i_valid <= 1'b0;
                drain();
            end
            send_face(random_face(), quiet_tail);
        end
        i_valid <= 1'b0;
        drain();
        repeat (80) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_normals.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
